// ===== src/assert_macros.svh =====
// ---------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers for the frame builder; compiled out with
// ASSERT_OFF.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
// property must hold at every clock edge outside reset
`define ASSERT_CHK(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// condition must never be true outside reset
`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define ASSERT_CHK(lbl, clk, rst_n, prop, msg)
`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg)
`endif

`endif

// ===== src/wsfb_pkg.sv =====
// ---------------------------------------------------------------------------
// wsfb_pkg
// Shared types and constants of the WebSocket frame builder.
// ---------------------------------------------------------------------------
package wsfb_pkg;

	// field widths
	localparam int LEN_W   = 63;
	localparam int KEY_W   = 32;
	localparam int BYTE_W  = 8;
	localparam int IN_W    = 112;
	localparam int HCNT_W  = 4;

	// default depth of the command queue
	localparam int QUEUE_DEPTH = 4;

	// item kinds on the input tuser
	localparam logic KIND_HDR  = 1'b0;
	localparam logic KIND_DATA = 1'b1;

	// length encoding constants
	localparam logic [LEN_W-1:0]  LEN7_MAX   = 63'd125;
	localparam logic [LEN_W-1:0]  LEN16_MAX  = 63'hFFFF;
	localparam logic [BYTE_W-1:0] LEN16_CODE = 8'd126;
	localparam logic [BYTE_W-1:0] LEN64_CODE = 8'd127;
	localparam logic [BYTE_W-1:0] LEN7_FIELD = 8'h7F;
	localparam logic [BYTE_W-1:0] MASK_BIT   = 8'h80;

	// extended length form of a header
	typedef enum logic [1:0] {
		EXT_NONE = 2'd0,
		EXT_16   = 2'd1,
		EXT_64   = 2'd2
	} ext_t;

	// command handed from front to back
	typedef struct packed {
		logic              hdr;     // 1: serialise a header, 0: emit one byte
		logic [BYTE_W-1:0] data;    // first header byte, or the byte to emit
		logic              last;    // last flag of the byte, or of the final header byte
		logic              err;     // error result
		logic              masked;
		ext_t              ext;
		logic [HCNT_W-1:0] hdr_n;   // header length in bytes
		logic [KEY_W-1:0]  key;
		logic [LEN_W-1:0]  len;
	} cmd_t;

endpackage

// ===== src/wsfb_queue.sv =====
// ---------------------------------------------------------------------------
// wsfb_queue
// Small command queue between the front and back parts.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module wsfb_queue #(
	parameter int DEPTH = wsfb_pkg::QUEUE_DEPTH   // at least 2
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  wsfb_pkg::cmd_t  push_cmd,
	output logic            full,
	input  logic            pop,
	output wsfb_pkg::cmd_t  head_cmd,
	output logic            empty
);

	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	wsfb_pkg::cmd_t     mem_q [DEPTH];
	logic [PTR_W-1:0]   wr_ptr_q;
	logic [PTR_W-1:0]   rd_ptr_q;
	logic [CNT_W-1:0]   count_q;

	assign full     = (count_q == CNT_W'(DEPTH));
	assign empty    = (count_q == '0);
	assign head_cmd = mem_q[rd_ptr_q];

	// storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_cmd;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	`ASSERT_NEVER(a_no_overflow, clk, arst_n, push && full && !pop, "queue push while full")
	`ASSERT_NEVER(a_no_underflow, clk, arst_n, pop && empty, "queue pop while empty")

endmodule

// ===== src/wsfb_front.sv =====
// ---------------------------------------------------------------------------
// wsfb_front
// Accepts header and payload items, tracks frame state, checks frame size
// and queues one command per item that gives output.
// ---------------------------------------------------------------------------
module wsfb_front (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_wr_en,
	input  logic [wsfb_pkg::LEN_W-1:0]    cfg_wr_data,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [wsfb_pkg::IN_W-1:0]     s_tdata,
	input  logic [0:0]                    s_tuser,
	output logic                          push,
	output wsfb_pkg::cmd_t                push_cmd,
	input  logic                          full
);

	logic [wsfb_pkg::LEN_W-1:0]  cap_q;
	logic [wsfb_pkg::LEN_W-1:0]  bytes_left_q;
	logic [wsfb_pkg::KEY_W-1:0]  key_q;
	logic                        mask_q;
	logic [1:0]                  phase_q;
	logic                        rej_q;

	logic                        accept;
	logic                        is_hdr;
	logic [3:0]                  opcode;
	logic                        masked;
	logic [wsfb_pkg::KEY_W-1:0]  key;
	logic [wsfb_pkg::LEN_W-1:0]  len;
	logic [wsfb_pkg::BYTE_W-1:0] pbyte;
	wsfb_pkg::ext_t              ext;
	logic [wsfb_pkg::HCNT_W-1:0] ext_n;
	logic [wsfb_pkg::HCNT_W-1:0] hdr_n;
	logic [wsfb_pkg::LEN_W:0]    total;
	logic                        over;
	logic                        data_live;
	logic [wsfb_pkg::BYTE_W-1:0] key_byte;

	// field unpacking
	assign is_hdr = (s_tuser[0] == wsfb_pkg::KIND_HDR);
	assign opcode = s_tdata[7:4];
	assign masked = s_tdata[8];
	assign key    = s_tdata[40:9];
	assign len    = s_tdata[103:41];
	assign pbyte  = s_tdata[111:104];

	assign s_tready = !full;
	assign accept   = s_tvalid && s_tready;

	// length form and header size
	always_comb begin
		if (len <= wsfb_pkg::LEN7_MAX) begin
			ext   = wsfb_pkg::EXT_NONE;
			ext_n = 4'd0;
		end else if (len <= wsfb_pkg::LEN16_MAX) begin
			ext   = wsfb_pkg::EXT_16;
			ext_n = 4'd2;
		end else begin
			ext   = wsfb_pkg::EXT_64;
			ext_n = 4'd8;
		end
	end

	assign hdr_n = 4'd2 + ext_n + (masked ? 4'd4 : 4'd0);

	// capacity check over header plus payload
	assign total = {1'b0, len} + {{(wsfb_pkg::LEN_W - wsfb_pkg::HCNT_W + 1){1'b0}}, hdr_n};
	assign over  = total > {1'b0, cap_q};

	// key byte for the current payload position, first key byte on top
	always_comb begin
		unique case (phase_q)
			2'd0: key_byte = key_q[31:24];
			2'd1: key_byte = key_q[23:16];
			2'd2: key_byte = key_q[15:8];
			2'd3: key_byte = key_q[7:0];
			default: key_byte = '0;
		endcase
	end

	assign data_live = (bytes_left_q != '0) && !rej_q;
	assign push      = accept && (is_hdr || data_live);

	// command build
	always_comb begin
		push_cmd        = '0;
		push_cmd.hdr    = is_hdr && !over;
		push_cmd.masked = masked;
		push_cmd.ext    = ext;
		push_cmd.hdr_n  = hdr_n;
		push_cmd.key    = key;
		push_cmd.len    = len;
		if (is_hdr) begin
			if (over) begin
				push_cmd.data = '0;
				push_cmd.last = 1'b1;
				push_cmd.err  = 1'b1;
			end else begin
				// fin on top, then rsv1..rsv3, opcode in the low nibble
				push_cmd.data = {s_tdata[0], s_tdata[1], s_tdata[2], s_tdata[3], opcode};
				push_cmd.last = (len == '0);
			end
		end else begin
			push_cmd.data = mask_q ? (pbyte ^ key_byte) : pbyte;
			push_cmd.last = (bytes_left_q == wsfb_pkg::LEN_W'(1));
		end
	end

	// capacity register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= '1;
		end else if (cfg_wr_en) begin
			cap_q <= cfg_wr_data;
		end
	end

	// frame state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bytes_left_q <= '0;
			key_q        <= '0;
			mask_q       <= 1'b0;
			phase_q      <= '0;
			rej_q        <= 1'b0;
		end else if (accept) begin
			if (is_hdr) begin
				bytes_left_q <= len;
				key_q        <= key;
				mask_q       <= masked;
				phase_q      <= '0;
				rej_q        <= over;
			end else if (bytes_left_q != '0) begin
				bytes_left_q <= bytes_left_q - 1'b1;
				if (!rej_q) begin
					phase_q <= phase_q + 1'b1;
				end
			end
		end
	end

endmodule

// ===== src/wsfb_back.sv =====
// ---------------------------------------------------------------------------
// wsfb_back
// Pops commands, serialises header bytes and drives the output register.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module wsfb_back (
	input  logic                          clk,
	input  logic                          arst_n,
	input  wsfb_pkg::cmd_t                head_cmd,
	input  logic                          empty,
	output logic                          pop,
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [wsfb_pkg::BYTE_W-1:0]   m_tdata,
	output logic                          m_tlast,
	output logic [0:0]                    m_tuser
);

	logic [wsfb_pkg::HCNT_W-1:0] idx_q;
	logic                        m_tvalid_q;
	logic [wsfb_pkg::BYTE_W-1:0] m_tdata_q;
	logic                        m_tlast_q;
	logic                        m_tuser_q;

	logic                        load;
	logic                        hdr_end;
	logic [wsfb_pkg::HCNT_W-1:0] key_start;
	logic [wsfb_pkg::HCNT_W-1:0] len_sel;
	logic [wsfb_pkg::HCNT_W-1:0] key_pos;
	logic [63:0]                 len64;
	logic [wsfb_pkg::BYTE_W-1:0] mbit;
	logic [wsfb_pkg::BYTE_W-1:0] hbyte;
	logic [wsfb_pkg::BYTE_W-1:0] obyte;
	logic                        olast;

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tlast  = m_tlast_q;
	assign m_tuser  = m_tuser_q;

	assign load    = !empty && (!m_tvalid_q || m_tready);
	assign hdr_end = (idx_q == head_cmd.hdr_n - 1'b1);
	assign pop     = load && (!head_cmd.hdr || hdr_end);

	// header byte selection
	assign len64 = {1'b0, head_cmd.len};
	assign mbit  = head_cmd.masked ? wsfb_pkg::MASK_BIT : '0;

	always_comb begin
		unique case (head_cmd.ext)
			wsfb_pkg::EXT_16: key_start = 4'd4;
			wsfb_pkg::EXT_64: key_start = 4'd10;
			default:          key_start = 4'd2;
		endcase
	end

	assign len_sel = key_start - 1'b1 - idx_q;
	assign key_pos = idx_q - key_start;

	always_comb begin
		priority if (idx_q == 4'd0) begin
			hbyte = head_cmd.data;
		end else if (idx_q == 4'd1) begin
			unique case (head_cmd.ext)
				wsfb_pkg::EXT_16: hbyte = mbit | wsfb_pkg::LEN16_CODE;
				wsfb_pkg::EXT_64: hbyte = mbit | wsfb_pkg::LEN64_CODE;
				default:          hbyte = mbit | (head_cmd.len[7:0] & wsfb_pkg::LEN7_FIELD);
			endcase
		end else if (idx_q < key_start) begin
			hbyte = len64[len_sel[2:0] * 8 +: 8];
		end else begin
			hbyte = head_cmd.key[(2'd3 - key_pos[1:0]) * 8 +: 8];
		end
	end

	assign obyte = head_cmd.hdr ? hbyte : head_cmd.data;
	assign olast = head_cmd.hdr ? (hdr_end && head_cmd.last) : head_cmd.last;

	// header byte counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
		end else if (load) begin
			idx_q <= pop ? '0 : idx_q + 1'b1;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (load) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			m_tdata_q <= obyte;
			m_tlast_q <= olast;
			m_tuser_q <= head_cmd.err;
		end
	end

	`ASSERT_NEVER(a_err_is_last, clk, arst_n, m_tvalid_q && m_tuser_q && !m_tlast_q, "error item without last")
	`ASSERT_NEVER(a_idx_in_hdr, clk, arst_n, !empty && head_cmd.hdr && (idx_q >= head_cmd.hdr_n), "header byte index past header")

endmodule

// ===== src/websocket_frame_builder_core.sv =====
// ---------------------------------------------------------------------------
// websocket_frame_builder_core
// WebSocket frame encoder: header and payload items in, frame bytes out.
// ---------------------------------------------------------------------------
// Each accepted input item is handled by the front part and, when it gives
// output, becomes a command in a QUEUE_DEPTH-entry queue; the input takes one
// item per cycle while that queue has room. The back part turns a payload
// command into one output byte per cycle while m_tready does not stall the
// output register, and a header command into 2 to 14 output bytes (2 + 0, 2
// or 8 length bytes + 4 key bytes when masked). A frame larger than the
// capacity register gives a single item with error and last set, and its
// payload items give nothing. The user must write the capacity register
// through cfg_wr_en/cfg_wr_data only while the block is idle (the block does
// not enforce it); the register resets to the largest 63-bit value.
module websocket_frame_builder_core #(
	parameter int QUEUE_DEPTH = wsfb_pkg::QUEUE_DEPTH
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_wr_en,
	input  logic [wsfb_pkg::LEN_W-1:0]  cfg_wr_data,   // buffer_capacity
	input  logic                        s_tvalid,
	output logic                        s_tready,
	// fin, rsv1, rsv2, rsv3, opcode[3:0], masked, key[31:0],
	// payload_length[62:0], payload_byte[7:0]
	input  logic [wsfb_pkg::IN_W-1:0]   s_tdata,
	input  logic [0:0]                  s_tuser,       // kind
	output logic                        m_tvalid,
	input  logic                        m_tready,
	output logic [wsfb_pkg::BYTE_W-1:0] m_tdata,       // out_byte
	output logic                        m_tlast,
	output logic [0:0]                  m_tuser        // error
);

	logic           push;
	logic           pop;
	logic           full;
	logic           empty;
	wsfb_pkg::cmd_t push_cmd;
	wsfb_pkg::cmd_t head_cmd;

	// item intake and frame tracking
	wsfb_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.s_tvalid    (s_tvalid),
		.s_tready    (s_tready),
		.s_tdata     (s_tdata),
		.s_tuser     (s_tuser),
		.push        (push),
		.push_cmd    (push_cmd),
		.full        (full)
	);

	// command queue
	wsfb_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cmd (push_cmd),
		.full     (full),
		.pop      (pop),
		.head_cmd (head_cmd),
		.empty    (empty)
	);

	// byte serialiser and output register
	wsfb_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.head_cmd (head_cmd),
		.empty    (empty),
		.pop      (pop),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.m_tuser  (m_tuser)
	);

endmodule
